// ===== rtl/srsc_pkg.sv =====
// Shared types and constants of the shadow return stack checker.
`timescale 1ns / 1ps

package srsc_pkg;

  // Stack geometry.
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths of the request and response channels.
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 9;
  localparam int unsigned ERR_W    = 32;

  // Request operation codes.
  localparam logic OP_CALL   = 1'b0;
  localparam logic OP_RETURN = 1'b1;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;       // Capture the request address.
    logic    push;        // Write the request address at the top and grow the stack.
    logic    pop;         // Read the top entry and shrink the stack.
    logic    err_bump;    // Count one return error, saturating.
    logic    set_status;  // Record the status of the current request.
    status_e status;
    logic    out_load;    // Load the response register.
  } srsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
  } srsc_sts_t;

endpackage

// ===== rtl/srsc_if.sv =====
// Request and response channel interfaces of the shadow return stack checker.
`timescale 1ns / 1ps

interface srsc_req_if import srsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

interface srsc_rsp_if import srsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DEPTH_W-1:0]  depth;
  logic [ERR_W-1:0]    errors_seen;

  modport source (output valid, output status, output depth, output errors_seen,
                  input ready);
  modport sink   (input valid, input status, input depth, input errors_seen,
                  output ready);
endinterface

// ===== rtl/srsc_dpath.sv =====
// Datapath: shadow stack memory, depth and error counters, response register.
`timescale 1ns / 1ps

module srsc_dpath import srsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ADDR_W-1:0]   req_address_i,
  input  srsc_cmd_t           cmd_i,
  output srsc_sts_t           sts_o,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [DEPTH_W-1:0]  rsp_depth_o,
  output logic [ERR_W-1:0]    rsp_errors_o
);

  logic [ADDR_W-1:0]   mem [STACK_DEPTH];
  logic [ADDR_W-1:0]   addr_q;
  logic [ADDR_W-1:0]   rdata_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ERR_W-1:0]    err_q, err_d;
  status_e             status_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [DEPTH_W-1:0]  out_depth_q;
  logic [ERR_W-1:0]    out_errors_q;
  logic [PTR_W-1:0]    wr_idx;
  logic [PTR_W-1:0]    rd_idx;

  // The write goes to the first free slot, the read to the current top entry.
  assign wr_idx = cnt_q[PTR_W-1:0];
  assign rd_idx = PTR_W'(cnt_q - CNT_W'(1));

  // Stack memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_idx] <= req_address_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_idx];
    end
  end

  // Stack depth counter.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Saturating error counter.
  always_comb begin
    err_d = err_q;
    if (cmd_i.err_bump && (err_q != '1)) begin
      err_d = err_q + ERR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // Address under check and status of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      addr_q <= req_address_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // Response register; counters are already final when it loads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_depth_q  <= DEPTH_W'(cnt_q);
      out_errors_q <= err_q;
    end
  end

  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.full  = (cnt_q == CNT_W'(STACK_DEPTH));
  assign sts_o.match = (rdata_q == addr_q);

  assign rsp_status_o = out_status_q;
  assign rsp_depth_o  = out_depth_q;
  assign rsp_errors_o = out_errors_q;

endmodule

// ===== rtl/srsc_ctrl.sv =====
// Controller: sequences calls, returns and the stack unwinding scan.
`timescale 1ns / 1ps

module srsc_ctrl import srsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_op_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output srsc_cmd_t cmd_o,
  input  srsc_sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       req_fire;
  logic       slot_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_PUSHED;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_o.latch = 1'b1;
          if (req_op_i == OP_CALL) begin
            cmd_o.set_status = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = ST_OVERFLOW;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.status = ST_PUSHED;
            end
            state_d = S_DONE;
          end else if (sts_i.empty) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EMPTY;
            cmd_o.err_bump   = 1'b1;
            state_d          = S_DONE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_CMP;
          end
        end
      end
      S_CMP: begin
        // Compare the entry popped last cycle; keep popping until a match.
        if (sts_i.match) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_MATCHED;
          state_d          = S_DONE;
        end else if (sts_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOMATCH;
          cmd_o.err_bump   = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response valid flag.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.out_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== rtl/shadow_return_stack_checker_core.sv =====
// Shadow return stack checker: top level joining controller and datapath.
//
// Usage: the request channel carries op (call or return) and a 64-bit
// address. A call pushes the address on a 256-entry shadow stack; a return
// pops entries from the top until one equals the address. Each request
// yields exactly one response with status, stack depth and the saturating
// count of return errors, in request order.
// A call, an overflowing call or a return on an empty stack goes from the
// idle state straight to the done state, which loads its response. A return
// pops its first entry when it is taken, then compares and pops further entries
// in the compare state until it reaches the done state, since the stack memory
// has one read port and the scan reads one entry per cycle. A new request is
// taken only in the idle state, once the last one has loaded its response.
// The next request is taken while an earlier response waits in the output
// register; if the receiver stalls, the following request finishes and
// then holds until the output register frees.
// Reset clears the depth, the error count and both handshakes; stack
// entries are not cleared and are only read after they were written.
`timescale 1ns / 1ps

module shadow_return_stack_checker_core import srsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srsc_req_if.sink  req_i,
  srsc_rsp_if.source rsp_o
);

  srsc_cmd_t cmd;
  srsc_sts_t sts;

  srsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srsc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_address_i (req_i.address),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_status_o  (rsp_o.status),
    .rsp_depth_o   (rsp_o.depth),
    .rsp_errors_o  (rsp_o.errors_seen)
  );

`ifndef NO_ASSERTIONS
  // A push never targets a full stack.
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.full)
    else $error("push issued on a full stack");

  // A pop never runs below the bottom of the stack.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.empty)
    else $error("pop issued on an empty stack");

  // A match status is only recorded when the popped entry equals the address.
  a_match_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.set_status && (cmd.status == ST_MATCHED)) |-> sts.match)
    else $error("match reported without equal entry");

  // Loading the response register always presents a response next cycle.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> rsp_o.valid)
    else $error("response loaded but not presented");
`endif

endmodule
